/* sv/kgr_pkg.sv */
// Shared types and constants for the kerned glyph row renderer.
// Holds the item and row payload structs, the mode codes and the coordinate constants.
// No dependencies.
package kgr_pkg;

	// Coordinate width: the pen and the line saturate at 2**COORD_BITS - 1.
	localparam int COORD_BITS = 12;
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
	localparam int GLYPH_SIZE = 16;

	// Signed working width for pen arithmetic, with room for steps and negative origins.
	localparam int WORK_W = COORD_BITS + 6;
	typedef logic signed [WORK_W-1:0] work_t;

	localparam work_t COORD_MAX_W     = work_t'(COORD_MAX);
	localparam work_t SPACE_ADVANCE_W = work_t'(8);
	localparam work_t KERN_GAP_W      = work_t'(3);
	localparam work_t FIXED_PITCH_W   = work_t'(10);

	// Item modes.
	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_KERN  = 3'd2;
	localparam logic [2:0] MODE_BOLD  = 3'd3;
	localparam logic [2:0] MODE_FIXED = 3'd4;

	localparam logic [7:0] SPACE_CODE = 8'd32;

	typedef struct packed {
		logic [2:0]  mode;
		logic [12:0] font_addr;
		logic [7:0]  font_byte;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [7:0]  char_code;
	} item_t;

	typedef struct packed {
		logic signed [COORD_BITS:0] row_x;
		logic [COORD_BITS-1:0]      row_y;
		logic [16:0]                row_bits;
		logic                       last;
	} row_t;

endpackage

/* sv/kerned_glyph_row_renderer_core.sv */
// Top level of the kerned glyph row renderer: font store, pen state and row emission.
// Depends on kgr_pkg for the payload structs, mode codes and coordinate constants.

// A font-write, string-start or unused-mode item is accepted back to back. A draw
// item (kerned, bold kerned or fixed pitch) runs through sixteen reads of the font
// store to find the lit columns, the LEFT and PLACE states to place the glyph and
// move the pen, and sixteen more reads that each give one row item, one a cycle
// while the row side does not stall. The font store has a single read port. No new
// item is taken until the draw is through. The font store needs no clearing pass,
// so items are taken straight after reset.
module kerned_glyph_row_renderer_core
	import kgr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  row_valid,
	input  logic  row_stall,
	output row_t  row
);

	localparam int WORD_DEPTH = 4096;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_LEFT  = 3'd2;
	localparam logic [2:0] ST_PLACE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]            state_q;
	logic [2:0]            mode_q;
	logic [7:0]            code_q;
	logic [COORD_BITS-1:0] pen_q;
	logic [COORD_BITS-1:0] line_q;
	logic [4:0]            issue_cnt_q;
	logic [15:0]           all_q;
	logic [4:0]            left_q;
	logic [4:0]            top_q;
	logic                  any_q;
	logic signed [COORD_BITS:0] origin_q;
	logic                  row_valid_q;
	row_t                  row_q;

	// Font store: even and odd bytes of each 16-bit glyph row in separate memories.
	logic [7:0] font_even_mem [WORD_DEPTH];
	logic [7:0] font_odd_mem  [WORD_DEPTH];
	logic [7:0] rd_even_s1;
	logic [7:0] rd_odd_s1;
	logic       rd_valid_s1;
	logic [3:0] rd_row_s1;

	logic        accept;
	logic        wr_even;
	logic        wr_odd;
	logic [11:0] wr_word;
	logic [11:0] rd_word;
	logic        rd_en;
	logic        row_free;
	logic        can_load;
	logic [15:0] plain_mask;
	logic [16:0] row_mask;
	logic [16:0] all_ext;
	logic [4:0]  left_c;
	logic [4:0]  top_c;
	logic [COORD_BITS:0]   row_y_sum;
	logic [COORD_BITS-1:0] row_y_c;
	work_t                 pen_step;
	logic [COORD_BITS-1:0] pen_stepped;
	work_t                 origin_raw;
	logic [COORD_BITS-1:0] right_c;

	function automatic logic [COORD_BITS-1:0] sat_coord(input work_t v);
		priority if (v[WORK_W-1]) begin
			return '0;
		end else if (v > COORD_MAX_W) begin
			return '1;
		end else begin
			return v[COORD_BITS-1:0];
		end
	endfunction

	// Handshake and memory port control.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign wr_word    = item.font_addr[12:1];
	assign wr_even    = accept && (item.mode == MODE_WRITE) && !item.font_addr[0];
	assign wr_odd     = accept && (item.mode == MODE_WRITE) && item.font_addr[0];

	// Glyph row r of code c sits at sheet row r + 240 - 16*(c/16), word column c%16.
	assign rd_word  = {~code_q[7:4], issue_cnt_q[3:0], code_q[3:0]};
	assign row_free = !row_valid_q || !row_stall;
	assign can_load = (state_q == ST_EMIT) && rd_valid_s1 && row_free;
	assign rd_en    = !issue_cnt_q[4] &&
		((state_q == ST_SCAN) || ((state_q == ST_EMIT) && (!rd_valid_s1 || row_free)));

	// Writes happen only in the idle state and reads only while drawing, so the
	// two never meet on the same entry in one cycle.
	always_ff @(posedge clk) begin
		if (wr_even) begin
			font_even_mem[wr_word] <= item.font_byte;
		end
		if (wr_odd) begin
			font_odd_mem[wr_word] <= item.font_byte;
		end
		if (rd_en) begin
			rd_even_s1 <= font_even_mem[rd_word];
			rd_odd_s1  <= font_odd_mem[rd_word];
			rd_row_s1  <= issue_cnt_q[3:0];
		end
	end

	// Turn the stored row (MSB leftmost) into a mask with bit k at column k.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			plain_mask[k]     = rd_even_s1[7 - k];
			plain_mask[k + 8] = rd_odd_s1[7 - k];
		end
		if (mode_q == MODE_BOLD) begin
			row_mask = {1'b0, plain_mask} | {plain_mask, 1'b0};
			all_ext  = {1'b0, all_q} | {all_q, 1'b0};
		end else begin
			row_mask = {1'b0, plain_mask};
			all_ext  = {1'b0, all_q};
		end
	end

	// Leftmost lit column of the plain glyph and rightmost lit column of the drawn one.
	always_comb begin
		left_c = 5'd16;
		for (int k = 15; k >= 0; k--) begin
			if (all_q[k]) begin
				left_c = 5'(k);
			end
		end
		top_c = 5'd0;
		for (int k = 0; k < 17; k++) begin
			if (all_ext[k]) begin
				top_c = 5'(k);
			end
		end
	end

	// Pen step before placement: fixed pitch, or the extra advance of a space.
	always_comb begin
		priority if (mode_q == MODE_FIXED) begin
			pen_step = FIXED_PITCH_W;
		end else if (code_q == SPACE_CODE) begin
			pen_step = SPACE_ADVANCE_W;
		end else begin
			pen_step = '0;
		end
		pen_stepped = sat_coord(work_t'(pen_q) + pen_step);
	end

	// Kerned placement: the leftmost lit column lands three pixels past the pen.
	assign origin_raw = work_t'(pen_q) - work_t'(left_q) + KERN_GAP_W;
	assign right_c    = sat_coord(origin_raw + work_t'(top_q));

	// Screen y of the row leaving the memory, saturated.
	assign row_y_sum = {1'b0, line_q} + (COORD_BITS + 1)'(rd_row_s1);
	assign row_y_c   = row_y_sum[COORD_BITS] ? '1 : row_y_sum[COORD_BITS-1:0];

	// Control sequence and pen state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_WRITE;
			code_q      <= '0;
			pen_q       <= '0;
			line_q      <= '0;
			issue_cnt_q <= '0;
			all_q       <= '0;
			left_q      <= '0;
			top_q       <= '0;
			any_q       <= 1'b0;
			origin_q    <= '0;
			rd_valid_s1 <= 1'b0;
			row_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				issue_cnt_q <= issue_cnt_q + 5'd1;
			end

			// Read data stays in place while the row register is full and stalled.
			priority if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if ((state_q == ST_EMIT) && !can_load) begin
				rd_valid_s1 <= rd_valid_s1;
			end else begin
				rd_valid_s1 <= 1'b0;
			end

			priority if (can_load) begin
				row_valid_q <= 1'b1;
			end else if (!row_stall) begin
				row_valid_q <= 1'b0;
			end else begin
				row_valid_q <= row_valid_q;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.mode)
							MODE_START: begin
								pen_q  <= sat_coord(work_t'(item.origin_x));
								line_q <= sat_coord(work_t'(item.origin_y));
							end
							MODE_KERN, MODE_BOLD, MODE_FIXED: begin
								mode_q      <= item.mode;
								code_q      <= item.char_code;
								all_q       <= '0;
								issue_cnt_q <= '0;
								state_q     <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_valid_s1) begin
						all_q <= all_q | plain_mask;
						if (rd_row_s1 == 4'd15) begin
							state_q <= ST_LEFT;
						end
					end
				end
				ST_LEFT: begin
					left_q <= left_c;
					top_q  <= top_c;
					any_q  <= |all_q;
					pen_q  <= pen_stepped;
					if (mode_q == MODE_FIXED) begin
						origin_q <= signed'({1'b0, pen_q});
					end
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					if (mode_q != MODE_FIXED) begin
						if (origin_raw > COORD_MAX_W) begin
							origin_q <= COORD_MAX_W[COORD_BITS:0];
						end else begin
							origin_q <= origin_raw[COORD_BITS:0];
						end
						if (any_q && (right_c > pen_q)) begin
							pen_q <= right_c;
						end
					end
					issue_cnt_q <= '0;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (can_load && (rd_row_s1 == 4'd15)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Row output register.
	always_ff @(posedge clk) begin
		if (can_load) begin
			row_q.row_x    <= origin_q;
			row_q.row_y    <= row_y_c;
			row_q.row_bits <= row_mask;
			row_q.last     <= (rd_row_s1 == 4'd15);
		end
	end

	assign row_valid = row_valid_q;
	assign row       = row_q;

endmodule

/* sv/kgr_checker.sv */
// Port-level checks for the kerned glyph row renderer, bound to its top level.
// Depends on kgr_pkg for the payload structs and mode codes.
module kgr_checker
	import kgr_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  item_valid,
	input logic  item_stall,
	input item_t item,
	input logic  row_valid,
	input logic  row_stall,
	input row_t  row
);

	// A row item waiting under stall keeps its contents.
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_stall |=> row_valid && $stable(row))
		else $error("stalled row item changed");

	// A draw item keeps the block busy in the next cycle.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall &&
		(item.mode == MODE_KERN || item.mode == MODE_BOLD || item.mode == MODE_FIXED)
		|=> item_stall)
		else $error("draw item did not occupy the block");

	// Font writes, string starts and unused modes leave the input free in the next cycle.
	a_quick_items: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall &&
		!(item.mode == MODE_KERN || item.mode == MODE_BOLD || item.mode == MODE_FIXED)
		|=> !item_stall)
		else $error("non-drawing item stalled the input");

	// Rows of one glyph follow one another without a gap.
	a_rows_continuous: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row.last |=> row_valid)
		else $error("gap inside a glyph's rows");

	// While a glyph is only partly delivered no new item is taken.
	a_busy_mid_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row.last |-> item_stall)
		else $error("item accepted in the middle of a glyph");

endmodule

bind kerned_glyph_row_renderer_core kgr_checker u_kgr_checker (.*);
